// ===== sv/rau_pkg.sv =====
package rau_pkg;

    localparam int unsigned OPERAND_WIDTH_DEF = 32;
    localparam int unsigned FIELD_W           = 32;
    localparam int unsigned KIND_W            = 2;
    localparam int unsigned STATUS_W          = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_ZERO_DEN = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    // classification handed from the front part to the back part
    typedef struct packed {
        logic zero_den;
        logic num_neg;
        logic den_neg;
    } rau_flags_t;

    localparam int unsigned FLAGS_W = $bits(rau_flags_t);

endpackage

// ===== sv/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: each input word carries two fractions (signed
// numerator and denominator, OPERAND_WIDTH bits used of each 32-bit field)
// and an operation in tuser (0 add, 1 subtract, 2 multiply, 3 divide); each
// output word carries the reduced numerator and denominator, sign-extended
// to 32 bits, with a status in tuser (0 ok, 1 zero denominator, 2 reduced
// part overflows OPERAND_WIDTH bits; both parts read 0 unless ok). Each part
// keeps its own sign. A front part takes a word, forms the cross products
// on one shared multiplier and hands them through a two-entry queue to a
// back part, which runs a binary gcd (one step a cycle) and then two
// restoring divisions; the back part sets the sustained rate. A finished
// result waits in the output register while the back part starts on the
// next queued word.
module rational_arithmetic_unit #(
    parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_num, left_den, right_num, right_den
    input  logic [127:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_num, result_den
    output logic [63:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned FW = rau_pkg::FIELD_W;
    localparam int unsigned QW = rau_pkg::FLAGS_W + 4 * W;

    rau_pkg::rau_flags_t push_flags, pop_flags;
    logic [2*W-1:0]      push_num, push_den, pop_num, pop_den;
    logic                push_valid, push_ready, pop_valid, pop_ready;
    logic [QW-1:0]       q_wr, q_rd;
    logic [W-1:0]        res_num, res_den;
    rau_pkg::status_t    res_status;

    // classify and multiply
    rau_front #(.W(W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (rau_pkg::kind_t'(s_axis_tuser)),
        .in_ln      (s_axis_tdata[W-1:0]),
        .in_ld      (s_axis_tdata[FW+W-1:FW]),
        .in_rn      (s_axis_tdata[2*FW+W-1:2*FW]),
        .in_rd      (s_axis_tdata[3*FW+W-1:3*FW]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_flags (push_flags),
        .push_num   (push_num),
        .push_den   (push_den)
    );

    assign q_wr = {push_flags, push_num, push_den};

    rau_queue #(.DW(QW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (q_wr),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (q_rd)
    );

    assign pop_flags = rau_pkg::rau_flags_t'(q_rd[QW-1:4*W]);
    assign pop_num   = q_rd[4*W-1:2*W];
    assign pop_den   = q_rd[2*W-1:0];

    // reduce and hold the result
    rau_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_flags  (pop_flags),
        .pop_num    (pop_num),
        .pop_den    (pop_den),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_status (res_status)
    );

    // sign-extend the reduced parts to the field width
    assign m_axis_tdata = {{(FW-W){res_den[W-1]}}, res_den,
                           {(FW-W){res_num[W-1]}}, res_num};
    assign m_axis_tuser = res_status;

endmodule

// ===== sv/rau_front.sv =====
module rau_front #(
    parameter int unsigned W = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rau_pkg::kind_t       in_kind,
    input  logic [W-1:0]         in_ln,
    input  logic [W-1:0]         in_ld,
    input  logic [W-1:0]         in_rn,
    input  logic [W-1:0]         in_rd,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rau_pkg::rau_flags_t  push_flags,
    output logic [2*W-1:0]       push_num,
    output logic [2*W-1:0]       push_den
);

    localparam int unsigned PW = 2 * W;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL0 = 6'b000010,
        F_MUL1 = 6'b000100,
        F_MUL2 = 6'b001000,
        F_SUM  = 6'b010000,
        F_PUSH = 6'b100000
    } fstate_t;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
        mag_of = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    fstate_t        st_reg, st_next;
    rau_pkg::kind_t kind_reg;
    logic [W-1:0]   lnm_reg, ldm_reg, rnm_reg, rdm_reg;
    logic           lns_reg, lds_reg, rns_reg, rds_reg;
    logic [PW-1:0]  p0_reg, p2_reg, pd_reg;
    logic           p0x_reg, p2x_reg, pdx_reg;
    logic [PW-1:0]  num_reg, den_reg;
    rau_pkg::rau_flags_t flags_reg;

    logic [W-1:0]   mul_a, mul_b;
    logic           mul_x;
    logic [PW-1:0]  prod;

    logic           an, bn, p0_ge;
    logic [PW-1:0]  sum_mag;
    logic           sum_neg;

    // shared multiplier, one product a cycle
    always_comb
    begin
        mul_a = lnm_reg;
        mul_b = rdm_reg;
        mul_x = lns_reg ^ rds_reg;
        case (st_reg)
            F_MUL0:
            begin
                mul_a = lnm_reg;
                mul_b = (kind_reg == rau_pkg::KIND_MUL) ? rnm_reg : rdm_reg;
                mul_x = lns_reg ^ ((kind_reg == rau_pkg::KIND_MUL) ? rns_reg : rds_reg);
            end
            F_MUL1:
            begin
                mul_a = ldm_reg;
                mul_b = (kind_reg == rau_pkg::KIND_DIV) ? rnm_reg : rdm_reg;
                mul_x = lds_reg ^ ((kind_reg == rau_pkg::KIND_DIV) ? rns_reg : rds_reg);
            end
            F_MUL2:
            begin
                mul_a = rnm_reg;
                mul_b = ldm_reg;
                mul_x = rns_reg ^ lds_reg;
            end
            default:
            begin
                mul_a = lnm_reg;
                mul_b = rdm_reg;
                mul_x = lns_reg ^ rds_reg;
            end
        endcase
        prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
    end

    // signed-magnitude add or subtract of the two cross products
    always_comb
    begin
        an    = p0x_reg & (p0_reg != '0);
        bn    = (p2x_reg ^ (kind_reg == rau_pkg::KIND_SUB)) & (p2_reg != '0);
        p0_ge = p0_reg >= p2_reg;
        if (an == bn)
        begin
            sum_mag = p0_reg + p2_reg;
            sum_neg = an;
        end
        else if (p0_ge)
        begin
            sum_mag = p0_reg - p2_reg;
            sum_neg = an;
        end
        else
        begin
            sum_mag = p2_reg - p0_reg;
            sum_neg = bn;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE: if (in_valid) st_next = F_MUL0;
            F_MUL0: st_next = F_MUL1;
            F_MUL1:
            begin
                if (kind_reg == rau_pkg::KIND_ADD || kind_reg == rau_pkg::KIND_SUB)
                    st_next = F_MUL2;
                else
                    st_next = F_SUM;
            end
            F_MUL2: st_next = F_SUM;
            F_SUM:  st_next = F_PUSH;
            F_PUSH: if (push_ready) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= F_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == F_IDLE && in_valid)
        begin
            kind_reg <= in_kind;
            lnm_reg  <= mag_of(in_ln);
            ldm_reg  <= mag_of(in_ld);
            rnm_reg  <= mag_of(in_rn);
            rdm_reg  <= mag_of(in_rd);
            lns_reg  <= in_ln[W-1];
            lds_reg  <= in_ld[W-1];
            rns_reg  <= in_rn[W-1];
            rds_reg  <= in_rd[W-1];
            p2_reg   <= '0;
            p2x_reg  <= 1'b0;
        end
        if (st_reg == F_MUL0)
        begin
            p0_reg  <= prod;
            p0x_reg <= mul_x;
        end
        if (st_reg == F_MUL1)
        begin
            pd_reg  <= prod;
            pdx_reg <= mul_x;
        end
        if (st_reg == F_MUL2)
        begin
            p2_reg  <= prod;
            p2x_reg <= mul_x;
        end
        if (st_reg == F_SUM)
        begin
            den_reg            <= pd_reg;
            flags_reg.zero_den <= (pd_reg == '0);
            flags_reg.den_neg  <= pdx_reg & (pd_reg != '0);
            if (kind_reg == rau_pkg::KIND_ADD || kind_reg == rau_pkg::KIND_SUB)
            begin
                num_reg           <= sum_mag;
                flags_reg.num_neg <= sum_neg;
            end
            else
            begin
                num_reg           <= p0_reg;
                flags_reg.num_neg <= an;
            end
        end
    end

    assign in_ready   = (st_reg == F_IDLE);
    assign push_valid = (st_reg == F_PUSH);
    assign push_flags = flags_reg;
    assign push_num   = num_reg;
    assign push_den   = den_reg;

endmodule

// ===== sv/rau_queue.sv =====
module rau_queue #(
    parameter int unsigned DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [DW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;
    assign rd_data  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ===== sv/rau_back.sv =====
module rau_back #(
    parameter int unsigned W = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  rau_pkg::rau_flags_t  pop_flags,
    input  logic [2*W-1:0]       pop_num,
    input  logic [2*W-1:0]       pop_den,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [W-1:0]         res_num,
    output logic [W-1:0]         res_den,
    output rau_pkg::status_t     res_status
);

    localparam int unsigned PW    = 2 * W;
    localparam int unsigned CNT_W = $clog2(PW);
    localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_GCD  = 5'b00010,
        B_DIVN = 5'b00100,
        B_DIVD = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    bstate_t          st_reg;
    logic [PW-1:0]    a_reg, b_reg, nq_reg, dq_reg, qn_reg;
    logic [PW-1:0]    rem_reg, quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             nneg_reg, dneg_reg, zero_reg;
    logic             vld_reg;
    logic [W-1:0]     onum_reg, oden_reg;
    rau_pkg::status_t ostat_reg;

    logic [PW:0]      rem_sh;
    logic             ge;
    logic [PW-1:0]    rem_nx, quo_nx;
    logic             cnt_last, out_free, fit_n, fit_d;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[PW-1]};
        ge       = rem_sh >= {1'b0, b_reg};
        rem_nx   = ge ? PW'(rem_sh - {1'b0, b_reg}) : rem_sh[PW-1:0];
        quo_nx   = {quo_reg[PW-2:0], ge};
        cnt_last = (cnt_reg == CNT_W'(PW - 1));
        out_free = !vld_reg || res_ready;
        fit_n    = (qn_reg < LIM) || (nneg_reg && qn_reg == LIM);
        fit_d    = (quo_reg < LIM) || (dneg_reg && quo_reg == LIM);
    end

    assign pop_ready = (st_reg == B_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= B_IDLE;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == B_OUT && out_free)
                vld_reg <= 1'b1;
            else if (res_ready)
                vld_reg <= 1'b0;
            case (st_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                        st_reg <= pop_flags.zero_den ? B_OUT : B_GCD;
                end
                B_GCD:
                begin
                    if (a_reg == '0 || a_reg == b_reg)
                        st_reg <= B_DIVN;
                end
                B_DIVN: if (cnt_last) st_reg <= B_DIVD;
                B_DIVD: if (cnt_last) st_reg <= B_OUT;
                B_OUT:
                begin
                    if (out_free)
                        st_reg <= B_IDLE;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                a_reg    <= pop_num;
                b_reg    <= pop_den;
                nq_reg   <= pop_num;
                dq_reg   <= pop_den;
                nneg_reg <= pop_flags.num_neg;
                dneg_reg <= pop_flags.den_neg;
                zero_reg <= pop_flags.zero_den;
            end
            B_GCD:
            begin
                // binary gcd step; common twos leave both parts as well
                if (a_reg == '0 || a_reg == b_reg)
                begin
                    rem_reg <= '0;
                    quo_reg <= nq_reg;
                    cnt_reg <= '0;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg  <= a_reg >> 1;
                    b_reg  <= b_reg >> 1;
                    nq_reg <= nq_reg >> 1;
                    dq_reg <= dq_reg >> 1;
                end
                else if (!a_reg[0])
                    a_reg <= a_reg >> 1;
                else if (!b_reg[0])
                    b_reg <= b_reg >> 1;
                else if (a_reg > b_reg)
                    a_reg <= (a_reg - b_reg) >> 1;
                else
                    b_reg <= (b_reg - a_reg) >> 1;
            end
            B_DIVN:
            begin
                rem_reg <= cnt_last ? '0 : rem_nx;
                quo_reg <= cnt_last ? dq_reg : quo_nx;
                cnt_reg <= cnt_last ? '0 : cnt_reg + CNT_W'(1);
                if (cnt_last)
                    qn_reg <= quo_nx;
            end
            B_DIVD:
            begin
                rem_reg <= rem_nx;
                quo_reg <= quo_nx;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    if (zero_reg)
                    begin
                        onum_reg  <= '0;
                        oden_reg  <= '0;
                        ostat_reg <= rau_pkg::STAT_ZERO_DEN;
                    end
                    else if (!fit_n || !fit_d)
                    begin
                        onum_reg  <= '0;
                        oden_reg  <= '0;
                        ostat_reg <= rau_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        onum_reg  <= nneg_reg ? (~qn_reg[W-1:0] + W'(1)) : qn_reg[W-1:0];
                        oden_reg  <= dneg_reg ? (~quo_reg[W-1:0] + W'(1)) : quo_reg[W-1:0];
                        ostat_reg <= rau_pkg::STAT_OK;
                    end
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign res_valid  = vld_reg;
    assign res_num    = onum_reg;
    assign res_den    = oden_reg;
    assign res_status = ostat_reg;

    // the gcd divisor never reaches zero while iterating
    a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_GCD |-> b_reg != '0)
        else $error("gcd divisor reached zero");

    // reduction is exact: the denominator division leaves no remainder
    a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_DIVD && cnt_last |=> rem_reg == '0)
        else $error("inexact reduction");

    // a good result never carries a zero denominator
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && ostat_reg == rau_pkg::STAT_OK |-> oden_reg != '0)
        else $error("ok result with zero denominator");

    // a zero-denominator item skips the gcd and division
    a_zero_skip: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_IDLE && pop_valid && pop_flags.zero_den |=> st_reg == B_OUT)
        else $error("zero denominator entered gcd");

endmodule
